### rtl/i2c_master_bit_engine_assert.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Property macros used by the top-level file to check the engine's internal logic.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Word types, command classes, engine phases and fixed constants.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Operation codes as they arrive on the input word.
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_SEND      = 3'd3;
    localparam logic [2:0] OP_WAIT_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_ACK  = 3'd5;
    localparam logic [2:0] OP_READ_NACK = 3'd6;
    localparam logic [2:0] OP_SCAN      = 3'd7;

    // Register word index, taken from paddr[2].
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd2;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [7:0]  LAST_SCAN_ADDRESS = 8'd254;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_is_input;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
        logic       scan_found;
        logic [7:0] found_address;
    } res_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_SEND,
        CMD_WAIT_ACK,
        CMD_READ_ACK,
        CMD_READ_NACK,
        CMD_SCAN
    } cmd_t;

    // A classified tick as it sits in the front queue.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       sda_in;
    } item_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_SN_L,
        PH_SN_H,
        PH_WA_A,
        PH_WA_B,
        PH_WA_P,
        PH_RD_L,
        PH_RD_H,
        PH_RA_L,
        PH_RA_H
    } phase_t;

    // How a sub-sequence ended; the scan uses this to pick its next step.
    typedef enum logic [2:0] {
        END_START,
        END_STOP,
        END_SEND,
        END_WAIT_OK,
        END_OTHER
    } end_kind_t;

endpackage

### rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts tick words, classifies the operation and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  in_t   cmd_word,
    input  logic  deq,
    output logic  item_valid,
    output item_t item
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    item_t      entry_reg [2];
    item_t      classified;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        case (cmd_word.operation)
            OP_START:     classified.cmd = CMD_START;
            OP_STOP:      classified.cmd = CMD_STOP;
            OP_SEND:      classified.cmd = CMD_SEND;
            OP_WAIT_ACK:  classified.cmd = CMD_WAIT_ACK;
            OP_READ_ACK:  classified.cmd = CMD_READ_ACK;
            OP_READ_NACK: classified.cmd = CMD_READ_NACK;
            OP_SCAN:      classified.cmd = CMD_SCAN;
            default:      classified.cmd = CMD_NONE;
        endcase
        classified.tx_byte = cmd_word.tx_byte;
        classified.sda_in  = cmd_word.sda_in;
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = deq && item_valid;

    always_comb
    begin
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### rtl/i2cm_res_queue.sv
// ----------------------------------------------------------------------------
// I2C master result queue
// Two-entry queue holding finished result words until they are popped.
// ----------------------------------------------------------------------------
module i2cm_res_queue
    import i2cm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    output logic res_full,
    input  res_t res_in,
    output logic empty,
    input  logic pop,
    output res_t res_word
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    res_t       entry_reg [2];
    logic       do_push;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_word = entry_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

### rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Advances the SCL/SDA sequencer by one tick per queued word and emits the
// pin levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    output logic        deq,
    input  logic        res_full,
    output logic        res_push,
    output res_t        res_in,
    input  logic [15:0] half_period_ticks,
    input  logic [7:0]  ack_timeout
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] tick_timer_reg, tick_timer_next;
    logic [7:0]  wait_count_reg, wait_count_next;
    logic [7:0]  scan_address_reg, scan_address_next;
    logic        read_ack_choice_reg, read_ack_choice_next;
    logic [1:0]  flags_reg, flags_next;
    logic        scan_op_reg, scan_op_next;
    logic [7:0]  rx_byte_reg, rx_byte_next;
    logic [7:0]  found_reg, found_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        rel_reg, rel_next;

    logic        step;
    logic        done_now;
    logic        sub_fire;
    end_kind_t   sub_kind;
    logic [15:0] tick_inc;
    logic [7:0]  shifted;
    logic [3:0]  bit_inc;

    assign step     = item_valid && !res_full;
    assign deq      = step;
    assign res_push = step;

    always_comb
    begin
        phase_next           = phase_reg;
        bit_count_next       = bit_count_reg;
        shift_byte_next      = shift_byte_reg;
        tick_timer_next      = tick_timer_reg;
        wait_count_next      = wait_count_reg;
        scan_address_next    = scan_address_reg;
        read_ack_choice_next = read_ack_choice_reg;
        flags_next           = flags_reg;
        scan_op_next         = scan_op_reg;
        rx_byte_next         = rx_byte_reg;
        found_next           = found_reg;
        scl_next             = scl_reg;
        sda_next             = sda_reg;
        rel_next             = rel_reg;
        done_now             = 1'b0;
        sub_fire             = 1'b0;
        sub_kind             = END_OTHER;
        tick_inc             = tick_timer_reg + 16'd1;
        shifted              = {shift_byte_reg[6:0], 1'b0};
        bit_inc              = bit_count_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd != CMD_NONE)
            begin
                scan_op_next    = (item.cmd == CMD_SCAN);
                tick_timer_next = 16'd0;
                case (item.cmd)
                    CMD_START:
                    begin
                        phase_next = PH_ST_A;
                        scl_next = 1'b1; sda_next = 1'b1; rel_next = 1'b0;
                    end
                    CMD_STOP:
                    begin
                        phase_next = PH_SP_A;
                        scl_next = 1'b0; sda_next = 1'b0; rel_next = 1'b0;
                    end
                    CMD_SEND:
                    begin
                        shift_byte_next = item.tx_byte;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_SN_L;
                        scl_next = 1'b0; sda_next = item.tx_byte[7]; rel_next = 1'b0;
                    end
                    CMD_WAIT_ACK:
                    begin
                        wait_count_next = 8'd0;
                        phase_next      = PH_WA_A;
                        sda_next = 1'b1; rel_next = 1'b1;
                    end
                    CMD_READ_ACK, CMD_READ_NACK:
                    begin
                        read_ack_choice_next = (item.cmd == CMD_READ_ACK);
                        shift_byte_next      = 8'd0;
                        bit_count_next       = 4'd0;
                        phase_next           = PH_RD_L;
                        scl_next = 1'b0; sda_next = 1'b1; rel_next = 1'b1;
                    end
                    CMD_SCAN:
                    begin
                        flags_next[1]     = 1'b0;
                        scan_address_next = 8'd0;
                        phase_next        = PH_ST_A;
                        scl_next = 1'b1; sda_next = 1'b1; rel_next = 1'b0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (phase_reg == PH_WA_P)
        begin
            if (!item.sda_in)
            begin
                flags_next[0] = 1'b0;
                scl_next = 1'b0; sda_next = 1'b1; rel_next = 1'b1;
                sub_fire = 1'b1;
                sub_kind = END_WAIT_OK;
            end
            else if (wait_count_reg >= ack_timeout)
            begin
                // Timeout: flag the failure and close the bus with one stop.
                flags_next[0]   = 1'b1;
                phase_next      = PH_SP_A;
                tick_timer_next = 16'd0;
                scl_next = 1'b0; sda_next = 1'b0; rel_next = 1'b0;
            end
            else
            begin
                wait_count_next = wait_count_reg + 8'd1;
            end
        end
        else if (tick_inc >= half_period_ticks)
        begin
            tick_timer_next = 16'd0;
            case (phase_reg)
                PH_ST_A:
                begin
                    phase_next = PH_ST_B;
                    scl_next = 1'b1; sda_next = 1'b0; rel_next = 1'b0;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b0; sda_next = 1'b0; rel_next = 1'b0;
                    sub_fire = 1'b1;
                    sub_kind = END_START;
                end
                PH_SP_A:
                begin
                    phase_next = PH_SP_B;
                    scl_next = 1'b1; sda_next = 1'b1; rel_next = 1'b0;
                end
                PH_SP_B:
                begin
                    sub_fire = 1'b1;
                    sub_kind = END_STOP;
                end
                PH_SN_L:
                begin
                    phase_next = PH_SN_H;
                    scl_next = 1'b1; rel_next = 1'b0;
                end
                PH_SN_H:
                begin
                    shift_byte_next = shifted;
                    bit_count_next  = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        scl_next = 1'b0; rel_next = 1'b0;
                        sub_fire = 1'b1;
                        sub_kind = END_SEND;
                    end
                    else
                    begin
                        phase_next = PH_SN_L;
                        scl_next = 1'b0; sda_next = shifted[7]; rel_next = 1'b0;
                    end
                end
                PH_WA_A:
                begin
                    phase_next = PH_WA_B;
                    scl_next = 1'b1; sda_next = 1'b1; rel_next = 1'b1;
                end
                PH_WA_B:
                begin
                    phase_next = PH_WA_P;
                end
                PH_RD_L:
                begin
                    // The data bit is sampled on the tick SCL goes high.
                    phase_next      = PH_RD_H;
                    shift_byte_next = {shift_byte_reg[6:0], item.sda_in};
                    scl_next = 1'b1; sda_next = 1'b1; rel_next = 1'b1;
                end
                PH_RD_H:
                begin
                    bit_count_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        phase_next = PH_RA_L;
                        scl_next = 1'b0; sda_next = !read_ack_choice_reg; rel_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_RD_L;
                        scl_next = 1'b0; sda_next = 1'b1; rel_next = 1'b1;
                    end
                end
                PH_RA_L:
                begin
                    phase_next = PH_RA_H;
                    scl_next = 1'b1; rel_next = 1'b0;
                end
                PH_RA_H:
                begin
                    scl_next = 1'b0; rel_next = 1'b0;
                    rx_byte_next = shift_byte_reg;
                    sub_fire = 1'b1;
                    sub_kind = END_OTHER;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    done_now   = 1'b1;
                end
            endcase
        end
        else
        begin
            tick_timer_next = tick_inc;
        end

        // End of a sub-sequence: plain commands finish, a scan chains on.
        if (sub_fire)
        begin
            tick_timer_next = 16'd0;
            if (!scan_op_reg || sub_kind == END_OTHER)
            begin
                phase_next = PH_IDLE;
                done_now   = 1'b1;
            end
            else
            begin
                case (sub_kind)
                    END_START:
                    begin
                        shift_byte_next = scan_address_reg;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_SN_L;
                        scl_next = 1'b0; sda_next = scan_address_reg[7]; rel_next = 1'b0;
                    end
                    END_SEND:
                    begin
                        wait_count_next = 8'd0;
                        phase_next      = PH_WA_A;
                        sda_next = 1'b1; rel_next = 1'b1;
                    end
                    END_WAIT_OK:
                    begin
                        found_next    = scan_address_reg;
                        flags_next[1] = 1'b1;
                        phase_next    = PH_IDLE;
                        done_now      = 1'b1;
                    end
                    default:
                    begin
                        if (scan_address_reg >= LAST_SCAN_ADDRESS)
                        begin
                            phase_next = PH_IDLE;
                            done_now   = 1'b1;
                        end
                        else
                        begin
                            scan_address_next = scan_address_reg + 8'd1;
                            phase_next        = PH_ST_A;
                            scl_next = 1'b1; sda_next = 1'b1; rel_next = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_in.scl_level     = scl_next;
        res_in.sda_level     = sda_next;
        res_in.sda_is_input  = rel_next;
        res_in.busy_res      = (phase_next != PH_IDLE);
        res_in.done_res      = done_now;
        res_in.rx_byte       = rx_byte_next;
        res_in.ack_failed    = flags_next[0];
        res_in.scan_found    = flags_next[1];
        res_in.found_address = found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            bit_count_reg       <= 4'd0;
            shift_byte_reg      <= 8'd0;
            tick_timer_reg      <= 16'd0;
            wait_count_reg      <= 8'd0;
            scan_address_reg    <= 8'd0;
            read_ack_choice_reg <= 1'b0;
            flags_reg           <= 2'd0;
            scan_op_reg         <= 1'b0;
            rx_byte_reg         <= 8'd0;
            found_reg           <= 8'd0;
            scl_reg             <= 1'b1;
            sda_reg             <= 1'b1;
            rel_reg             <= 1'b0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            bit_count_reg       <= bit_count_next;
            shift_byte_reg      <= shift_byte_next;
            tick_timer_reg      <= tick_timer_next;
            wait_count_reg      <= wait_count_next;
            scan_address_reg    <= scan_address_next;
            read_ack_choice_reg <= read_ack_choice_next;
            flags_reg           <= flags_next;
            scan_op_reg         <= scan_op_next;
            rx_byte_reg         <= rx_byte_next;
            found_reg           <= found_next;
            scl_reg             <= scl_next;
            sda_reg             <= sda_next;
            rel_reg             <= rel_next;
        end
    end

endmodule

### rtl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master sequencer with queue-style word ports and an APB
// configuration port.
// ----------------------------------------------------------------------------
// Each input word is one timer tick carrying an optional command and the
// sampled SDA level; each accepted word yields exactly one result word with
// the SCL/SDA levels to drive and the command status for that tick. The block
// sustains one word per clock cycle while the result queue has room: the engine
// updates its sequencer state once per tick, and two-entry queues in front of
// and behind it let the input and result sides stall independently. A word
// passes through the front queue and then the result queue before it appears
// on the result side. The half period (address 0x0) and acknowledge timeout
// (address 0x4) should only be written while no tick is in flight.
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_t         cmd_word,
    output logic        empty,
    input  logic        pop,
    output res_t        res_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] half_period_reg;
    logic [7:0]  ack_timeout_reg;
    logic        cfg_write;

    logic        item_valid;
    item_t       item;
    logic        deq;
    logic        res_full;
    logic        res_push;
    res_t        res_in;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_HALF_PERIOD)
            begin
                half_period_reg <= pwdata[15:0];
            end
            else
            begin
                ack_timeout_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_ACK_TIMEOUT)
        begin
            prdata = {24'd0, ack_timeout_reg};
        end
        else
        begin
            prdata = {16'd0, half_period_reg};
        end
    end

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd_word   (cmd_word),
        .deq        (deq),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cm_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item              (item),
        .deq               (deq),
        .res_full          (res_full),
        .res_push          (res_push),
        .res_in            (res_in),
        .half_period_ticks (half_period_reg),
        .ack_timeout       (ack_timeout_reg)
    );

    i2cm_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res_in   (res_in),
        .empty    (empty),
        .pop      (pop),
        .res_word (res_word)
    );

    // The engine must never hand a word to a full result queue.
    `I2CM_ASSERT_IMP(a_no_res_overflow, res_push, !res_full, "result queue overflow")

    // A word accepted at the input is visible to the engine on the next cycle.
    `I2CM_ASSERT_NXT(a_accept_reaches_engine, push && !full, item_valid,
                     "accepted word missing from front queue")

    // A completing tick always reports the engine as no longer busy.
    `I2CM_ASSERT_IMP(a_done_not_busy, res_push && res_in.done_res, !res_in.busy_res,
                     "done reported while busy")

endmodule
